/* design/mtp_pkg.sv */
package mtp_pkg;

	localparam int CordicSteps = 16;
	localparam int DistTol = 41;
	localparam int AngleTol = 41;
	localparam logic signed [27:0] PiQ24 = 28'sd52707179;
	localparam logic signed [19:0] PiQ12 = 20'sd12868;
	localparam logic signed [19:0] TwoPiQ12 = 20'sd25736;

	localparam logic [2:0] REG_GOAL_X = 3'd0;
	localparam logic [2:0] REG_GOAL_Y = 3'd1;
	localparam logic [2:0] REG_GOAL_HEADING = 3'd2;
	localparam logic [2:0] REG_GAIN_RHO = 3'd3;
	localparam logic [2:0] REG_GAIN_ALPHA = 3'd4;
	localparam logic [2:0] REG_GAIN_BETA = 3'd5;
	localparam logic [2:0] REG_MAX_LIN = 3'd6;
	localparam logic [2:0] REG_MAX_ANG = 3'd7;

	typedef struct packed {
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [15:0] ph;
		logic               reached;
	} mtp_job_t;

	typedef struct packed {
		logic signed [15:0] linear_speed;
		logic signed [15:0] angular_speed;
		logic               goal_reached;
	} mtp_res_t;

	function automatic logic [27:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0: atan_entry = 28'd13176795;
			5'd1: atan_entry = 28'd7778716;
			5'd2: atan_entry = 28'd4110060;
			5'd3: atan_entry = 28'd2086331;
			5'd4: atan_entry = 28'd1047214;
			5'd5: atan_entry = 28'd524117;
			5'd6: atan_entry = 28'd262123;
			5'd7: atan_entry = 28'd131069;
			default: atan_entry = 28'd65536 >> (i - 5'd8);
		endcase
	endfunction

	// truncating remainder by 2*pi, magnitude below eight turns
	function automatic logic signed [19:0] rem_two_pi(input logic signed [19:0] v);
		logic [19:0] mag;
		mag = v[19] ? 20'(-v) : v;
		if (mag >= 20'(4 * TwoPiQ12)) mag = mag - 20'(4 * TwoPiQ12);
		if (mag >= 20'(2 * TwoPiQ12)) mag = mag - 20'(2 * TwoPiQ12);
		if (mag >= 20'(TwoPiQ12)) mag = mag - 20'(TwoPiQ12);
		rem_two_pi = v[19] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

/* design/mtp_front.sv */
module mtp_front import mtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	input  logic signed [15:0] goal_x,
	input  logic signed [15:0] goal_y,
	input  logic signed [15:0] goal_heading,
	output logic               job_valid,
	input  logic               job_ready,
	output mtp_job_t           job,
	output logic [17:0]        rho
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_SQRT = 3'b010,
		F_HOLD = 3'b100
	} fst_t;

	fst_t                fst_q;
	logic signed [16:0]  dx_q, dy_q, th_q;
	logic signed [15:0]  ph_q;
	logic [34:0]         rem_q;
	logic [34:0]         root_q;
	logic [4:0]          cnt_q;
	logic [34:0]         trial;
	logic [34:0]         bitv;
	logic signed [16:0]  dxn, dyn;
	logic [16:0]         th_abs;

	assign dxn = 17'(pose_x) - 17'(goal_x);
	assign dyn = 17'(pose_y) - 17'(goal_y);
	assign full = (fst_q != F_IDLE);
	assign bitv = 35'd1 << {cnt_q, 1'b0};
	assign trial = root_q + bitv;
	assign th_abs = th_q[16] ? 17'(-th_q) : th_q;
	assign job_valid = (fst_q == F_HOLD);
	assign job.dx = dx_q;
	assign job.dy = dy_q;
	assign job.ph = ph_q;
	assign job.reached = (root_q < 35'(DistTol)) && (th_abs < 17'(AngleTol));
	assign rho = root_q[17:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
			cnt_q <= '0;
		end else begin
			case (fst_q)
				F_IDLE: if (push) begin
					fst_q <= F_SQRT;
					cnt_q <= 5'd17;
				end
				F_SQRT: begin
					if (cnt_q == 5'd0) fst_q <= F_HOLD;
					else cnt_q <= cnt_q - 5'd1;
				end
				F_HOLD: if (job_ready) fst_q <= F_IDLE;
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fst_q == F_IDLE && push) begin
			dx_q <= dxn;
			dy_q <= dyn;
			ph_q <= pose_heading;
			th_q <= 17'(pose_heading) - 17'(goal_heading);
			root_q <= '0;
			rem_q <= 35'(34'(dxn) * 34'(dxn)) + 35'(34'(dyn) * 34'(dyn));
		end else if (fst_q == F_SQRT) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				root_q <= (root_q >> 1) + bitv;
			end else begin
				root_q <= root_q >> 1;
			end
		end
	end

endmodule

/* design/mtp_queue.sv */
module mtp_queue import mtp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mtp_job_t in_job,
	input  logic [17:0] in_rho,
	output logic     out_valid,
	input  logic     out_ready,
	output mtp_job_t out_job,
	output logic [17:0] out_rho
);

	mtp_job_t    job_q [2];
	logic [17:0] rho_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        wr, rd;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;
	assign out_job = job_q[rp_q];
	assign out_rho = rho_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			job_q[wp_q] <= in_job;
			rho_q[wp_q] <= in_rho;
		end
	end

endmodule

/* design/mtp_back.sv */
module mtp_back import mtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  mtp_job_t           job,
	input  logic [17:0]        rho,
	input  logic signed [15:0] goal_heading,
	input  logic [15:0]        gain_rho,
	input  logic [15:0]        gain_alpha,
	input  logic [15:0]        gain_beta,
	input  logic [14:0]        lin_limit,
	input  logic [14:0]        ang_limit,
	output logic               res_valid,
	input  logic               res_ready,
	output mtp_res_t           res
);

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_CORD = 7'b0000010,
		B_ANG  = 7'b0000100,
		B_MUL  = 7'b0001000,
		B_SUM  = 7'b0010000,
		B_SAT  = 7'b0100000,
		B_OUT  = 7'b1000000
	} bst_t;

	bst_t               bst_q;
	mtp_job_t           job_q;
	logic [17:0]        rho_q;
	logic signed [27:0] x_q, y_q, z_q;
	logic [4:0]         i_q;
	logic signed [19:0] alpha_q, beta_q;
	logic signed [35:0] pv_q, pa_q, pb_q;
	logic signed [37:0] v_q, w_q;
	mtp_res_t           res_q;
	logic               done_q;

	logic signed [27:0] xs, ys, ta;
	logic signed [27:0] zr;
	logic signed [19:0] ang, a0, a1, b0, b1;
	logic signed [37:0] vs, ws;
	logic signed [37:0] lin_lim, ang_lim;

	assign job_ready = (bst_q == B_IDLE);
	assign res_valid = (bst_q == B_OUT);
	assign res = res_q;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign ta = 28'(atan_entry(i_q));
	assign zr = (z_q + 28'sd2048) >>> 12;
	assign ang = (job_q.dx == 0 && job_q.dy == 0) ? 20'sd0 : 20'(zr);
	assign a0 = ang - 20'(job_q.ph) + PiQ12 + (job_q.dx[16] ? PiQ12 : 20'sd0);
	assign a1 = rem_two_pi(a0) - PiQ12;
	assign b0 = 20'(goal_heading) - 20'(job_q.ph) - alpha_q + PiQ12;
	assign b1 = rem_two_pi(b0) - PiQ12;
	assign vs = (v_q + 38'sd2048) >>> 12;
	assign ws = (w_q + 38'sd2048) >>> 12;
	assign lin_lim = 38'($signed({1'b0, lin_limit}));
	assign ang_lim = 38'($signed({1'b0, ang_limit}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_IDLE;
			i_q <= '0;
			done_q <= 1'b0;
		end else begin
			case (bst_q)
				B_IDLE: if (job_valid) begin
					bst_q <= job.reached ? B_OUT : B_CORD;
					i_q <= '0;
					done_q <= 1'b0;
				end
				B_CORD: begin
					if (y_q == 0 || i_q == 5'(CordicSteps - 1)) bst_q <= B_ANG;
					i_q <= i_q + 5'd1;
				end
				B_ANG: begin
					if (!done_q) done_q <= 1'b1;
					else bst_q <= B_MUL;
				end
				B_MUL: bst_q <= B_SUM;
				B_SUM: bst_q <= B_SAT;
				B_SAT: bst_q <= B_OUT;
				B_OUT: if (res_ready) bst_q <= B_IDLE;
				default: bst_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (bst_q)
			B_IDLE: if (job_valid) begin
				job_q <= job;
				rho_q <= rho;
				res_q <= '{linear_speed: '0, angular_speed: '0, goal_reached: 1'b1};
				if (job.dx[16]) begin
					x_q <= -(28'(job.dx) <<< 8);
					y_q <= -(28'(job.dy) <<< 8);
					z_q <= job.dy[16] ? -PiQ24 : PiQ24;
				end else begin
					x_q <= 28'(job.dx) <<< 8;
					y_q <= 28'(job.dy) <<< 8;
					z_q <= '0;
				end
			end
			B_CORD: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + ta;
				end else if (y_q < 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - ta;
				end
			end
			B_ANG: begin
				if (!done_q) alpha_q <= a1;
				else beta_q <= b1;
			end
			B_MUL: begin
				pv_q <= 36'(gain_rho) * 36'(rho_q);
				pa_q <= 36'($signed({1'b0, gain_alpha})) * 36'(alpha_q);
				pb_q <= 36'($signed({1'b0, gain_beta})) * 36'(beta_q);
			end
			B_SUM: begin
				v_q <= 38'(pv_q);
				w_q <= 38'(pa_q) - 38'(pb_q);
			end
			B_SAT: begin
				res_q.goal_reached <= 1'b0;
				if (vs > lin_lim)
					res_q.linear_speed <= job_q.dx[16] ? -16'(lin_limit)
						: 16'(lin_limit);
				else
					res_q.linear_speed <= job_q.dx[16] ? -16'(vs) : 16'(vs);
				if (ws > ang_lim)
					res_q.angular_speed <= 16'(ang_limit);
				else if (ws < -ang_lim)
					res_q.angular_speed <= -16'(ang_limit);
				else
					res_q.angular_speed <= 16'(ws);
			end
			default: ;
		endcase
	end

endmodule

/* design/mtp_outq.sv */
module mtp_outq import mtp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mtp_res_t in_res,
	output logic     empty,
	input  logic     pop,
	output mtp_res_t out_res
);

	mtp_res_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_ready = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign wr = in_valid && in_ready;
	assign rd = pop && !empty;
	assign out_res = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_res;
	end

endmodule

/* design/move_to_pose_controller.sv */
// Move-to-pose drive controller.
// Input side is a queue: drive pose_x, pose_y, pose_heading and raise push;
// the beat is taken at a clock edge with push high and full low.
// Result side is a queue: while empty is low, linear_speed, angular_speed and
// goal_reached show the oldest result; pop high at an edge takes that beat.
// Configuration: cfg_valid/cfg_ready with cfg_index (0..7) and cfg_data;
// cfg_ready is always high. Write only while no pose is in flight.
// The front end takes a pose, forms the offset and runs an 18-step bit-pair
// integer square root; full stays high from each accepted beat until the job
// queue takes its job. The back end runs up to 16 CORDIC steps, then angle
// wrap, multiply, sum and saturate stages. Both run concurrently, so the front
// end can take a new pose while the back end works on an earlier job.
// Goal-reached poses skip the CORDIC and all later stages and go straight to
// the output.
// Reset (arst_n low) empties all queues and loads the register defaults.
// When the receiver stalls, two results are held, then the back end and the
// job queue fill, and the front end holds its job with full high.
module move_to_pose_controller import mtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] linear_speed,
	output logic signed [15:0] angular_speed,
	output logic               goal_reached,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic signed [15:0] goal_x_q, goal_y_q, goal_heading_q;
	logic [15:0]        gain_rho_q, gain_alpha_q, gain_beta_q;
	logic [14:0]        max_lin_q, max_ang_q;

	logic        fj_valid, fj_ready, qj_valid, qj_ready, r_valid, r_ready;
	mtp_job_t    fj, qj;
	logic [17:0] qrho;
	mtp_res_t    r, o;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
			goal_heading_q <= '0;
			gain_rho_q <= 16'd4096;
			gain_alpha_q <= 16'd4096;
			gain_beta_q <= 16'd4096;
			max_lin_q <= 15'd4096;
			max_ang_q <= 15'd4096;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GOAL_X: goal_x_q <= cfg_data;
				REG_GOAL_Y: goal_y_q <= cfg_data;
				REG_GOAL_HEADING: goal_heading_q <= cfg_data;
				REG_GAIN_RHO: gain_rho_q <= cfg_data;
				REG_GAIN_ALPHA: gain_alpha_q <= cfg_data;
				REG_GAIN_BETA: gain_beta_q <= cfg_data;
				REG_MAX_LIN: max_lin_q <= cfg_data[14:0];
				REG_MAX_ANG: max_ang_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	logic [17:0] front_rho;

	mtp_front u_front (
		.clk, .arst_n, .push, .full, .pose_x, .pose_y, .pose_heading,
		.goal_x(goal_x_q), .goal_y(goal_y_q), .goal_heading(goal_heading_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj), .rho(front_rho)
	);

	mtp_queue u_queue (
		.clk, .arst_n, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
		.in_rho(front_rho), .out_valid(qj_valid), .out_ready(qj_ready),
		.out_job(qj), .out_rho(qrho)
	);

	mtp_back u_back (
		.clk, .arst_n, .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
		.rho(qrho), .goal_heading(goal_heading_q), .gain_rho(gain_rho_q),
		.gain_alpha(gain_alpha_q), .gain_beta(gain_beta_q),
		.lin_limit(max_lin_q), .ang_limit(max_ang_q),
		.res_valid(r_valid), .res_ready(r_ready), .res(r)
	);

	mtp_outq u_outq (
		.clk, .arst_n, .in_valid(r_valid), .in_ready(r_ready), .in_res(r),
		.empty, .pop, .out_res(o)
	);

	assign linear_speed = o.linear_speed;
	assign angular_speed = o.angular_speed;
	assign goal_reached = o.goal_reached;

endmodule

/* dv/move_to_pose_controller_test.sv */
module move_to_pose_controller_test import mtp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		logic               reached;
	} drive_cmd_t;

	class drive_scoreboard;
		logic signed [15:0] gx, gy, gh;
		logic [15:0] k_rho, k_alpha, k_beta;
		logic [14:0] lim_lin, lim_ang;
		drive_cmd_t pending[$];
		int errors;
		int checked;
		int reached_seen;

		function new();
			gx = 0;
			gy = 0;
			gh = 0;
			k_rho = 4096;
			k_alpha = 4096;
			k_beta = 4096;
			lim_lin = 4096;
			lim_ang = 4096;
			errors = 0;
			checked = 0;
			reached_seen = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_GOAL_X: gx = val;
				REG_GOAL_Y: gy = val;
				REG_GOAL_HEADING: gh = val;
				REG_GAIN_RHO: k_rho = val;
				REG_GAIN_ALPHA: k_alpha = val;
				REG_GAIN_BETA: k_beta = val;
				REG_MAX_LIN: lim_lin = val[14:0];
				REG_MAX_ANG: lim_ang = val[14:0];
				default: ;
			endcase
		endfunction

		function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		function longint root_floor(longint n);
			longint r;
			r = longint'($sqrt(real'(n)));
			while (r * r > n) r--;
			while ((r + 1) * (r + 1) <= n) r++;
			return r;
		endfunction

		function longint bearing(longint yv, longint xv);
			longint x, y, z, nx, ny;
			longint tab[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
				262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
			if (xv == 0 && yv == 0) return 0;
			x = xv * 256;
			y = yv * 256;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? 52707179 : -52707179;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < CordicSteps; i++) begin
				if (y == 0) break;
				if (y > 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z += tab[i];
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z -= tab[i];
				end
				x = nx;
				y = ny;
			end
			return floor_shift(z + 2048, 12);
		endfunction

		function longint clamp(longint v, longint lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		function void note_pose(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] ph);
			longint dx, dy, rho, theta, a, al, be, v, w;
			drive_cmd_t c;
			dx = longint'(px) - longint'(gx);
			dy = longint'(py) - longint'(gy);
			rho = root_floor(dx * dx + dy * dy);
			theta = longint'(ph) - longint'(gh);
			if (theta < 0) theta = -theta;
			if (rho < DistTol && theta < AngleTol) begin
				c.lin = 0;
				c.ang = 0;
				c.reached = 1;
			end else begin
				a = bearing(dy, dx);
				al = a - ph + 12868 + (dx < 0 ? 12868 : 0);
				al = (al % 25736) - 12868;
				be = longint'(gh) - ph - al + 12868;
				be = (be % 25736) - 12868;
				v = floor_shift(longint'(k_rho) * rho + 2048, 12);
				if (dx < 0) v = -v;
				w = floor_shift(longint'(k_alpha) * al - longint'(k_beta) * be + 2048, 12);
				c.lin = 16'(clamp(v, lim_lin));
				c.ang = 16'(clamp(w, lim_ang));
				c.reached = 0;
			end
			pending.push_back(c);
		endfunction

		function void report_mismatch(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endfunction

		function void check_cmd(logic signed [15:0] lin, logic signed [15:0] ang,
			logic reached);
			drive_cmd_t c;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: %0d %0d %0b",
					lin, ang, reached));
				return;
			end
			c = pending.pop_front();
			checked++;
			if (reached === 1'b1) reached_seen++;
			if (lin !== c.lin)
				report_mismatch($sformatf("linear_speed %0d, wanted %0d", lin, c.lin));
			if (ang !== c.ang)
				report_mismatch($sformatf("angular_speed %0d, wanted %0d", ang, c.ang));
			if (reached !== c.reached)
				report_mismatch($sformatf("goal_reached %0b, wanted %0b", reached,
					c.reached));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [15:0] pose_x, pose_y, pose_heading;
	logic empty;
	logic pop;
	logic signed [15:0] linear_speed, angular_speed;
	logic goal_reached;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	drive_scoreboard sb;
	bit calm;
	bit rx_idle_ok;
	int poses_sent;

	move_to_pose_controller dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
		logic signed [15:0] ph);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push <= 1'b1;
		pose_x <= px;
		pose_y <= py;
		pose_heading <= ph;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_pose(px, py, ph);
		poses_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_pose();
		int k;
		logic signed [15:0] px, py, ph;
		k = $urandom_range(0, 9);
		px = 16'($urandom);
		py = 16'($urandom);
		ph = 16'($urandom);
		if (k < 3) begin
			px = sb.gx + $signed(16'($urandom_range(0, 80)) - 16'sd40);
			py = sb.gy + $signed(16'($urandom_range(0, 80)) - 16'sd40);
			ph = sb.gh + $signed(16'($urandom_range(0, 90)) - 16'sd45);
		end else if (k < 5) begin
			px = sb.gx + $signed(16'($urandom_range(0, 8000)) - 16'sd4000);
			py = sb.gy + $signed(16'($urandom_range(0, 8000)) - 16'sd4000);
		end
		send_pose(px, py, ph);
	endtask

	task automatic random_config(bit extreme);
		for (int r = 0; r < 8; r++) begin
			logic [15:0] v;
			v = 16'($urandom);
			if (extreme) v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			if (r == REG_MAX_LIN || r == REG_MAX_ANG) v[15] = 1'b0;
			if (r <= REG_GOAL_HEADING && !extreme && $urandom_range(0, 1))
				v = 16'(16'($urandom_range(0, 8000)) - 16'd4000);
			write_reg(3'(r), v);
		end
	endtask

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_cmd(linear_speed, angular_speed, goal_reached);
		end
	end

	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!calm && rx_idle_ok && $urandom_range(0, 6) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		sb = new();
		calm = 1'b0;
		rx_idle_ok = 1'b1;
		poses_sent = 0;
		push = 1'b0;
		pose_x = 0;
		pose_y = 0;
		pose_heading = 0;
		cfg_valid = 1'b0;
		cfg_index = REG_GOAL_X;
		cfg_data = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pose(0, 0, 0);
		send_pose(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_pose(-16'sd32768, -16'sd32768, -16'sd32768);
		send_pose(16'sh7FFF, -16'sd32768, 0);
		send_pose(-16'sd32768, 16'sh7FFF, 16'sd12868);
		send_pose(40, 0, 40);
		send_pose(41, 0, 0);
		send_pose(0, 0, 41);
		send_pose(-40, 0, -40);
		send_pose(-100, 0, 0);
		send_pose(0, -100, 0);
		send_pose(0, 100, -16'sd12868);
		send_pose(-100, -1, 0);
		send_pose(-100, 1, 0);
		drain();
		write_reg(REG_MAX_LIN, 0);
		write_reg(REG_MAX_ANG, 0);
		send_pose(1000, 1000, 1000);
		drain();
		write_reg(REG_MAX_LIN, 16'h7FFF);
		write_reg(REG_MAX_ANG, 16'h7FFF);
		write_reg(REG_GAIN_RHO, 16'hFFFF);
		write_reg(REG_GAIN_ALPHA, 16'hFFFF);
		write_reg(REG_GAIN_BETA, 16'hFFFF);
		send_pose(-16'sd32768, -16'sd32768, 16'sh7FFF);
		send_pose(16'sh7FFF, 16'sd5, -16'sd32768);
		drain();
		write_reg(REG_GOAL_X, 16'h7FFF);
		write_reg(REG_GOAL_Y, 16'h8000);
		write_reg(REG_GOAL_HEADING, 16'h7FFF);
		send_pose(-16'sd32768, 16'sh7FFF, -16'sd32768);
		send_pose(16'sh7FFF, -16'sd32768, 16'sh7FFF);

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			random_config(ph == 2 || ph == 7);
			for (int i = 0; i < 150; i++) random_pose();
			if (ph == 5) begin
				push <= 1'b0;
				@(posedge clk);
				while (sb.pending.size() != 0) @(posedge clk);
			end
		end
		drain();
		calm = 1'b1;
		rx_idle_ok = 1'b0;
		for (int i = 0; i < 120; i++) random_pose();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d poses over corner cases and 12 random register sets; %0d checked,",
			poses_sent, sb.checked);
		$display("%0d of them at the goal.", sb.reached_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
